/* design/tsf_pkg.sv */
package tsf_pkg;

    localparam int PACKET_BYTES      = 188;
    // Table depth is a power of two, so a PID maps to an entry by its low bits
    localparam int PID_TABLE_ENTRIES = 8192;

    localparam int PID_W      = 13;
    localparam int PID_ADDR_W = $clog2(PID_TABLE_ENTRIES);
    localparam int LEFT_W     = $clog2(PACKET_BYTES);

    localparam logic [7:0] SYNC_BYTE = 8'h47;

    localparam logic CMD_DATA      = 1'b0;
    localparam logic CMD_PID_WRITE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       data_byte;
        logic [PID_W-1:0] pid_sel;
        logic             pid_enable;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_first;
        logic       packet_last;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } cell_t;

    typedef struct packed {
        logic                  en;
        logic [PID_ADDR_W-1:0] addr;
        logic                  val;
    } tbl_wr_t;

endpackage

/* design/ts_sync_pid_filter.sv */
// Transport stream sync recovery and PID filter. Each input transaction is
// either a stream byte (cmd 0) or a write of one PID enable bit (cmd 1); both
// are taken at one per clock while s_ready is high. Stream bytes run through
// a chain of 188 byte cells; a packet is confirmed when the byte leaving the
// chain is 0x47 at a packet boundary and the byte arriving is 0x47 too, and
// its 188 bytes are then forwarded with first and last marks if its PID is
// enabled, else dropped. The first 188 bytes only fill the chain, so a
// forwarded byte is pushed out by the transaction of a later byte and reaches
// the output through a registered buffer. After reset the 8192-entry PID
// table is swept to zero, one entry per cycle; s_ready stays low while the
// sweep runs. A two-entry output buffer takes one more transaction when the
// output stalls; s_ready then stays low until the stall ends.
module ts_sync_pid_filter (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tsf_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output tsf_pkg::out_t m_payload
);

    localparam int PB = tsf_pkg::PACKET_BYTES;
    localparam logic [tsf_pkg::LEFT_W-1:0] FIRST_LEFT = tsf_pkg::LEFT_W'(PB - 1);

    tsf_pkg::cell_t line [PB];
    tsf_pkg::cell_t head;

    logic accept;
    logic shift;
    logic tbl_busy;
    logic tbl_q;
    logic buf_full;

    tsf_pkg::tbl_wr_t                tbl_wr;
    logic [tsf_pkg::PID_W-1:0]       rd_pid;
    logic [7:0]                      nxt_b1;
    logic [7:0]                      nxt_b2;

    logic [tsf_pkg::LEFT_W-1:0] left_reg;
    logic [tsf_pkg::LEFT_W-1:0] left_next;
    logic                       passing_reg;
    logic                       passing_next;
    logic                       push;
    tsf_pkg::out_t              push_data;
    logic [7:0]                 leaving;

    assign s_ready = !tbl_busy && !buf_full;
    assign accept  = s_valid && s_ready;
    assign shift   = accept && (s_payload.cmd == tsf_pkg::CMD_DATA);

    assign head.valid = 1'b1;
    assign head.data  = s_payload.data_byte;

    for (genvar i = 0; i < PB; i++) begin : g_cell
        if (i == 0) begin : g_head
            tsf_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .cell_in (head),
                .cell_out(line[i])
            );
        end else begin : g_body
            tsf_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .cell_in (line[i-1]),
                .cell_out(line[i])
            );
        end
    end

    // Look up the PID of the chain as it stands after this edge
    always_comb begin
        nxt_b1 = shift ? line[PB-3].data : line[PB-2].data;
        nxt_b2 = shift ? line[PB-4].data : line[PB-3].data;
        rd_pid = {nxt_b1[4:0], nxt_b2};
    end

    always_comb begin
        tbl_wr.en   = accept && (s_payload.cmd == tsf_pkg::CMD_PID_WRITE);
        tbl_wr.addr = s_payload.pid_sel[tsf_pkg::PID_ADDR_W-1:0];
        tbl_wr.val  = s_payload.pid_enable;
    end

    tsf_pid_table u_table (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (tbl_wr),
        .rd_addr(rd_pid[tsf_pkg::PID_ADDR_W-1:0]),
        .rd_q   (tbl_q),
        .busy   (tbl_busy)
    );

    assign leaving = line[PB-1].data;

    always_comb begin
        left_next              = left_reg;
        passing_next           = passing_reg;
        push                   = 1'b0;
        push_data.out_byte     = leaving;
        push_data.packet_first = 1'b0;
        push_data.packet_last  = 1'b0;
        if (shift && line[PB-1].valid) begin
            if (left_reg != '0) begin
                push                  = passing_reg;
                push_data.packet_last = (left_reg == tsf_pkg::LEFT_W'(1));
                left_next             = left_reg - 1'b1;
                if (left_next == '0) begin
                    passing_next = 1'b0;
                end
            end else if ((leaving == tsf_pkg::SYNC_BYTE)
                         && (s_payload.data_byte == tsf_pkg::SYNC_BYTE)) begin
                passing_next           = tbl_q;
                left_next              = FIRST_LEFT;
                push                   = tbl_q;
                push_data.packet_first = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            passing_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            passing_reg <= passing_next;
        end
    end

    tsf_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (buf_full),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

/* design/tsf_cell.sv */
module tsf_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift,
    input  tsf_pkg::cell_t cell_in,
    output tsf_pkg::cell_t cell_out
);

    logic       valid_reg;
    logic [7:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            data_reg <= cell_in.data;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.data  = data_reg;

endmodule

/* design/tsf_pid_table.sv */
module tsf_pid_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tsf_pkg::tbl_wr_t               wr,
    input  logic [tsf_pkg::PID_ADDR_W-1:0] rd_addr,
    output logic                           rd_q,
    output logic                           busy
);

    localparam logic [tsf_pkg::PID_ADDR_W-1:0] LAST_ADDR =
        tsf_pkg::PID_ADDR_W'(tsf_pkg::PID_TABLE_ENTRIES - 1);

    logic                           mem [tsf_pkg::PID_TABLE_ENTRIES];
    logic                           clearing_reg;
    logic [tsf_pkg::PID_ADDR_W-1:0] clr_cnt_reg;
    logic                           q_reg;

    logic                           we;
    logic [tsf_pkg::PID_ADDR_W-1:0] waddr;
    logic                           wdata;

    always_comb begin
        we    = clearing_reg || wr.en;
        waddr = clearing_reg ? clr_cnt_reg : wr.addr;
        wdata = clearing_reg ? 1'b0 : wr.val;
    end

    // Sweep every entry to zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Forward a same-cycle write so the read never sees a stale bit
        if (we && (waddr == rd_addr)) begin
            q_reg <= wdata;
        end else begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_q = q_reg;
    assign busy = clearing_reg;

endmodule

/* design/tsf_out_buf.sv */
module tsf_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tsf_pkg::out_t push_data,
    output logic          full,
    output logic          m_valid,
    input  logic          m_ready,
    output tsf_pkg::out_t m_payload
);

    logic          main_valid_reg;
    tsf_pkg::out_t main_data_reg;
    logic          skid_valid_reg;
    tsf_pkg::out_t skid_data_reg;

    logic main_free;

    assign main_free = !main_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            // Hold the transaction aside while the output stalls
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_payload = main_data_reg;

endmodule
